/* design/lnrx_pkg.sv */
`timescale 1ns / 1ps

package lnrx_pkg;

  localparam int LenW     = 7;
  localparam int TypeW    = 3;
  localparam int TagW     = 40;
  localparam int CfgIdxW  = 3;
  localparam int NumTags  = 4;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChStar    = 8'h2A;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPaused   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTagOne   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTagTwo   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTagThree = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTagFour  = 3'd4;

  // Sentence type codes
  localparam logic [TypeW-1:0] TypeUnknown = 3'd0;
  localparam logic [TypeW-1:0] TypeOne     = 3'd1;
  localparam logic [TypeW-1:0] TypeTwo     = 3'd2;
  localparam logic [TypeW-1:0] TypeThree   = 3'd3;
  localparam logic [TypeW-1:0] TypeFour    = 3'd4;

  localparam logic [TagW-1:0] TagOneRst   = 40'd155966067787;
  localparam logic [TagW-1:0] TagTwoRst   = 40'd155848754242;
  localparam logic [TagW-1:0] TagThreeRst = 40'd155798422594;
  localparam logic [TagW-1:0] TagFourRst  = 40'd155748090946;

  typedef struct packed {
    logic                          paused;
    logic [NumTags-1:0][TagW-1:0]  tags;
  } cfg_t;

  typedef struct packed {
    logic [LenW-1:0]  line_length;
    logic [TypeW-1:0] sentence_type;
    logic             has_checksum;
    logic             checksum_ok;
  } res_t;

  // Characters other than 0-9 and A-F count as zero, lowercase a-f included
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch[3:0];
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      v = ch[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

/* design/lnrx_cfg_regs.sv */
`timescale 1ns / 1ps

module lnrx_cfg_regs
  import lnrx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [TagW-1:0]    wr_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.paused  <= 1'b0;
      cfg_q.tags[0] <= TagOneRst;
      cfg_q.tags[1] <= TagTwoRst;
      cfg_q.tags[2] <= TagThreeRst;
      cfg_q.tags[3] <= TagFourRst;
    end else if (wr_en_i) begin
      case (wr_index_i)
        RegPaused:   cfg_q.paused  <= wr_data_i[0];
        RegTagOne:   cfg_q.tags[0] <= wr_data_i;
        RegTagTwo:   cfg_q.tags[1] <= wr_data_i;
        RegTagThree: cfg_q.tags[2] <= wr_data_i;
        RegTagFour:  cfg_q.tags[3] <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/lnrx_line_core.sv */
`timescale 1ns / 1ps

module lnrx_line_core
  import lnrx_pkg::*;
#(
  parameter int LINE_LENGTH = 120
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output logic       emit_o,
  output res_t       res_o
);

  localparam logic [LenW-1:0] LineMax = LenW'(LINE_LENGTH - 1);

  logic [LenW-1:0] wi_q, wi_d;
  logic [TagW-1:0] hdr_q, hdr_d;
  logic [7:0]      xor_q, xor_d;
  logic [31:0]     last4_q, last4_d;

  logic            restart;
  logic            store;
  logic [LenW-1:0] base_wi;
  logic [TagW-1:0] base_hdr;
  logic [7:0]      base_xor;
  logic [7:0]      tail_xor;
  logic [7:0]      sum;
  logic            live;

  assign live    = step_i && !cfg_i.paused;
  assign restart = (byte_i == ChDollar) || (byte_i == ChNewline);
  assign emit_o  = live && (byte_i == ChNewline);

  // Result from the line as it stands before this byte
  always_comb begin
    res_o.line_length   = wi_q;
    res_o.sentence_type = TypeUnknown;
    if (wi_q >= LenW'(5)) begin
      if (hdr_q == cfg_i.tags[0]) begin
        res_o.sentence_type = TypeOne;
      end else if (hdr_q == cfg_i.tags[1]) begin
        res_o.sentence_type = TypeTwo;
      end else if (hdr_q == cfg_i.tags[2]) begin
        res_o.sentence_type = TypeThree;
      end else if (hdr_q == cfg_i.tags[3]) begin
        res_o.sentence_type = TypeFour;
      end
    end
    res_o.has_checksum = (wi_q >= LenW'(4)) && (last4_q[31:24] == ChStar);
    tail_xor = 8'd0;
    if (wi_q >= LenW'(5)) begin
      // drop the star, both digits and the last byte from the running sum
      tail_xor = xor_q ^ last4_q[7:0] ^ last4_q[15:8] ^ last4_q[23:16] ^ last4_q[31:24];
    end
    sum = {hex_value(last4_q[23:16]), hex_value(last4_q[15:8])} ^ tail_xor;
    res_o.checksum_ok = res_o.has_checksum && (sum == 8'd0);
  end

  always_comb begin
    base_wi  = restart ? '0 : wi_q;
    base_hdr = restart ? '0 : hdr_q;
    base_xor = restart ? '0 : xor_q;
    store    = base_wi < LineMax;
    wi_d     = wi_q;
    hdr_d    = hdr_q;
    xor_d    = xor_q;
    last4_d  = last4_q;
    if (live) begin
      wi_d  = base_wi;
      hdr_d = base_hdr;
      xor_d = base_xor;
      if (store) begin
        wi_d    = base_wi + LenW'(1);
        last4_d = {last4_q[23:0], byte_i};
        if (base_wi < LenW'(5)) begin
          hdr_d[8*(3'd4 - base_wi[2:0]) +: 8] = byte_i;
        end
        if (base_wi != '0) begin
          xor_d = base_xor ^ byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q    <= '0;
      hdr_q   <= '0;
      xor_q   <= '0;
      last4_q <= '0;
    end else begin
      wi_q    <= wi_d;
      hdr_q   <= hdr_d;
      xor_q   <= xor_d;
      last4_q <= last4_d;
    end
  end

endmodule

/* design/nmea_line_receiver_top.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o    rx_byte_i
// out      output     out_valid_o/out_ready_i  line_length_o, sentence_type_o,
//                                              has_checksum_o, checksum_ok_o
// cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte per cycle while the result register is free or being drained: a
// byte sits in the input register, then updates the line state and, on a
// newline, loads the result register, which raises result valid.
// Reset clears line state and loads the default tags; no clearing pass.
// A held result stalls the input register only; the input side keeps
// flowing while the result register is free or being drained.
module nmea_line_receiver_top
  import lnrx_pkg::*;
#(
  parameter int LINE_LENGTH = 120
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LenW-1:0]    line_length_o,
  output logic [TypeW-1:0]   sentence_type_o,
  output logic               has_checksum_o,
  output logic               checksum_ok_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TagW-1:0]    cfg_data_i
);

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       emit;
  logic       advance;
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       out_vld_q;

  assign cfg_ready_o = 1'b1;

  lnrx_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the held byte when the result register can take a result
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  lnrx_line_core #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign line_length_o   = res_q.line_length;
  assign sentence_type_o = res_q.sentence_type;
  assign has_checksum_o  = res_q.has_checksum;
  assign checksum_ok_o   = res_q.checksum_ok;

endmodule
